/* hdl/tsd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants of the taut-string TV denoiser
// Sizes, segment entry layout, divider handshake and sequencer states.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int MAX_LEN  = 64;
  localparam int IDX_W    = $clog2(MAX_LEN);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int SMP_W    = 32;
  localparam int LAM_W    = 31;
  localparam int RISE_W   = SMP_W + IDX_W + 2;
  localparam int CMP_W    = RISE_W + 1;
  localparam int DIV_BITS = 4;
  localparam int DIV_ITERS = (RISE_W + DIV_BITS - 1) / DIV_BITS;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMBDA       = 1'b0,
    CFG_START_OFFSET = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]         len;
    logic signed [RISE_W-1:0] rise;
    logic signed [SMP_W-1:0]  slope;
  } seg_t;

  typedef struct packed {
    logic                     start;
    logic signed [RISE_W-1:0] num;
    logic [CNT_W-1:0]         den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [SMP_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PT_EMIT,
    ST_ADD_START,
    ST_ADD_FIRST,
    ST_ADD_MERGE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PUSH,
    ST_KNOT_RD,
    ST_KNOT_CMP,
    ST_KNOT_EMIT,
    ST_FL_RD,
    ST_FL_DATA,
    ST_FL_END
  } state_e;

  // clamp to the 32-bit signed range
  function automatic logic signed [SMP_W-1:0] sat32(input logic signed [CMP_W-1:0] v);
    logic signed [CMP_W-1:0] hi;
    logic signed [CMP_W-1:0] lo;
    hi = {{(CMP_W-SMP_W+1){1'b0}}, {(SMP_W-1){1'b1}}};
    lo = {{(CMP_W-SMP_W+1){1'b1}}, {(SMP_W-1){1'b0}}};
    if (v > hi) begin
      return hi[SMP_W-1:0];
    end else if (v < lo) begin
      return lo[SMP_W-1:0];
    end
    return v[SMP_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/tsd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_in_if / tsd_out_if: sample and run channels
// Valid/ready channels carrying one sample or one constant run.
// ----------------------------------------------------------------------------
interface tsd_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      sample;
  logic                    last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface tsd_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [31:0]              level;
  logic [tsd_pkg::CNT_W-1:0]       run_length;
  logic                            last_run;
  logic                            overflow;
  modport source (output valid, level, run_length, last_run, overflow, input ready);
  modport sink   (input valid, level, run_length, last_run, overflow, output ready);
endinterface
`default_nettype wire

/* hdl/tsd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* hdl/tsd_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_div: iterative slope divider
// Signed rise over unsigned length, truncated toward zero, saturated to
// 32 bits; zero length gives zero. Radix-16 restoring, one pulse on done.
// ----------------------------------------------------------------------------
module tsd_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tsd_pkg::div_req_t  req_i,
  output      tsd_pkg::div_rsp_t  rsp_o
);

  localparam int QW   = tsd_pkg::DIV_ITERS * tsd_pkg::DIV_BITS;
  localparam int IT_W = $clog2(tsd_pkg::DIV_ITERS + 1);

  logic                        busy_q, busy_d;
  logic                        fin_q, fin_d;
  logic                        done_q, done_d;
  logic [IT_W-1:0]             it_q, it_d;
  logic [tsd_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic [tsd_pkg::CNT_W-1:0]   den_q, den_d;
  logic [QW-1:0]               quo_q, quo_d;
  logic                        neg_q, neg_d;
  logic signed [31:0]          res_q, res_d;

  always_comb begin
    logic [tsd_pkg::CNT_W:0]        r;
    logic [QW-1:0]                  q;
    logic [tsd_pkg::RISE_W-1:0]     mag;
    logic signed [tsd_pkg::CMP_W-1:0] sv;
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    it_d   = it_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    res_d  = res_q;
    r      = '0;
    q      = quo_q;
    mag    = req_i.num[tsd_pkg::RISE_W-1] ? tsd_pkg::RISE_W'(-req_i.num) : req_i.num;
    sv     = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      it_d   = '0;
      rem_d  = '0;
      den_d  = req_i.den;
      neg_d  = req_i.num[tsd_pkg::RISE_W-1];
      quo_d  = QW'(mag);
    end else if (busy_q) begin
      r = {1'b0, rem_q};
      for (int k = 0; k < tsd_pkg::DIV_BITS; k++) begin
        r = {r[tsd_pkg::CNT_W-1:0], q[QW-1]};
        q = {q[QW-2:0], 1'b0};
        if (r >= {1'b0, den_q}) begin
          r    = r - {1'b0, den_q};
          q[0] = 1'b1;
        end
      end
      rem_d = r[tsd_pkg::CNT_W-1:0];
      quo_d = q;
      it_d  = it_q + IT_W'(1);
      if (it_q == IT_W'(tsd_pkg::DIV_ITERS - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
    if (fin_q) begin
      sv = {1'b0, quo_q[tsd_pkg::RISE_W-1:0]};
      if (neg_q) begin
        sv = -sv;
      end
      res_d  = (den_q == '0) ? '0 : tsd_pkg::sat32(sv);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      neg_q  <= 1'b0;
      res_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      it_q   <= it_d;
      rem_q  <= rem_d;
      den_q  <= den_d;
      quo_q  <= quo_d;
      neg_q  <= neg_d;
      res_q  <= res_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = res_q;

endmodule
`default_nettype wire

/* hdl/taut_string_tv1_denoiser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// taut_string_tv1_denoiser: streaming 1-D total-variation (l1) denoiser
// Taut-string method over two segment deques held in RAM; emits runs.
// ----------------------------------------------------------------------------
// Samples (signed Q16.16) arrive one transaction each, the last one flagged.
// The block keeps the concave majorant and convex minorant of the tube as two
// deques of segments (length, rise, slope), each in its own 64-entry RAM with
// registered read data; a sequencer reads, merges and writes back entries.
// Output transactions are constant runs (level, length). Runs are emitted
// whenever the first slopes cross, and the rest at the last sample. With
// lambda 0 or a one-sample signal every sample passes through as a run of
// one. A signal reaching 64 samples without the flag is closed early and the
// runs it emits at the last sample carry overflow. lambda and start_offset
// are sampled at the first sample of a signal. A later sample merges tail
// segments into each deque and runs the shared radix-16 slope divider for
// each deque whose tail merged, then emits runs on a slope crossing; at the
// last sample the surviving deque is drained. Output stalls can hold the
// emission of any run. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module taut_string_tv1_denoiser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i,
  tsd_in_if.sink                             in_i,
  tsd_out_if.source                          out_o
);

  localparam int RW = tsd_pkg::RISE_W;
  localparam int CW = tsd_pkg::CNT_W;
  localparam int IW = tsd_pkg::IDX_W;
  localparam int SW = $bits(tsd_pkg::seg_t);

  tsd_pkg::state_e state_q, state_d;

  // configuration
  logic [tsd_pkg::LAM_W-1:0] lambda_q, lambda_d;
  logic signed [31:0]        start_q, start_d;

  // per-signal state
  logic [tsd_pkg::LAM_W-1:0] lam_q, lam_d;
  logic                      passthru_q, passthru_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             knot_x_q, knot_x_d;
  logic signed [RW-1:0]      knot_y_q, knot_y_d;
  logic [CW-1:0]             exp_x_q, exp_x_d;
  logic signed [RW-1:0]      exp_y_q, exp_y_d;
  logic [CW-1:0]             uh_q, uh_d, us_q, us_d;
  logic [CW-1:0]             lh_q, lh_d, ls_q, ls_d;

  // per-sample working registers
  logic signed [31:0]        s_q, s_d;
  logic                      close_q, close_d;
  logic                      ovf_q, ovf_d;
  logic                      side_q, side_d;        // 0 upper, 1 lower
  logic                      knot_mode_q, knot_mode_d;
  logic signed [RW-1:0]      x_q, x_d;
  logic [CW-1:0]             acc_len_q, acc_len_d;
  logic signed [RW-1:0]      acc_rise_q, acc_rise_d;
  logic signed [31:0]        acc_sl_q, acc_sl_d;
  logic signed [31:0]        em_level_q, em_level_d;
  logic [CW-1:0]             em_len_q, em_len_d;
  logic [CW-1:0]             fl_k_q, fl_k_d;
  logic                      pend_v_q, pend_v_d;
  logic signed [31:0]        pend_level_q, pend_level_d;
  logic [CW-1:0]             pend_len_q, pend_len_d;

  // output register
  logic                      ovalid_q, ovalid_d;
  logic signed [31:0]        o_level_q, o_level_d;
  logic [CW-1:0]             o_len_q, o_len_d;
  logic                      o_last_q, o_last_d;
  logic                      o_ovf_q, o_ovf_d;
  logic                      out_free;

  // RAM ports
  logic          up_we, up_re, lo_we, lo_re;
  logic [IW-1:0] up_waddr, up_raddr, lo_waddr, lo_raddr;
  logic [SW-1:0] up_wdata, lo_wdata, up_rdata, lo_rdata;
  tsd_pkg::seg_t up_rd, lo_rd, cur_rd, wseg;

  tsd_pkg::div_req_t div_req;
  tsd_pkg::div_rsp_t div_rsp;

  // helpers
  logic [CW-1:0]              cur_head, cur_size, tail_sum, next_tail_sum;
  logic [CW:0]                push_pos;
  logic signed [RW-1:0]       s_ext, in_ext, lam_ext, start_ext, cfg_lam_ext;
  logic signed [CW+32:0]      prod;
  logic signed [tsd_pkg::CMP_W-1:0] rise_c, prod_c;
  logic [CW-1:0]              cnt_inc;
  logic                       in_ovf, in_close, in_first, in_pt, merge;
  logic signed [RW-1:0]       r_u, r_l, nrise;
  logic [CW-1:0]              nlen;

  assign up_rd  = tsd_pkg::seg_t'(up_rdata);
  assign lo_rd  = tsd_pkg::seg_t'(lo_rdata);
  assign cur_rd = side_q ? lo_rd : up_rd;

  assign cur_head      = side_q ? lh_q : uh_q;
  assign cur_size      = side_q ? ls_q : us_q;
  assign tail_sum      = cur_head + cur_size - CW'(1);
  assign next_tail_sum = cur_head + cur_size - CW'(2);
  assign push_pos      = {1'b0, cur_head} + {1'b0, cur_size};

  assign s_ext       = {{(RW-32){s_q[31]}}, s_q};
  assign in_ext      = {{(RW-32){in_i.sample[31]}}, in_i.sample};
  assign lam_ext     = {{(RW-tsd_pkg::LAM_W){1'b0}}, lam_q};
  assign cfg_lam_ext = {{(RW-tsd_pkg::LAM_W){1'b0}}, lambda_q};
  assign start_ext   = {{(RW-32){start_q[31]}}, start_q};

  // exact length * slope for the merge test
  assign prod   = $signed({1'b0, acc_len_q}) * cur_rd.slope;
  assign rise_c = tsd_pkg::CMP_W'(acc_rise_q);
  assign prod_c = tsd_pkg::CMP_W'(prod);

  assign out_free = !ovalid_q || out_o.ready;

  assign wseg = '{len: acc_len_q, rise: acc_rise_q, slope: acc_sl_q};

  always_comb begin
    lambda_d = lambda_q;
    start_d  = start_q;
    if (cfg_we_i) begin
      case (tsd_pkg::cfg_idx_e'(cfg_idx_i))
        tsd_pkg::CFG_LAMBDA:       lambda_d = cfg_data_i[tsd_pkg::LAM_W-1:0];
        tsd_pkg::CFG_START_OFFSET: start_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    lam_d        = lam_q;
    passthru_d   = passthru_q;
    count_d      = count_q;
    knot_x_d     = knot_x_q;
    knot_y_d     = knot_y_q;
    exp_x_d      = exp_x_q;
    exp_y_d      = exp_y_q;
    uh_d         = uh_q;
    us_d         = us_q;
    lh_d         = lh_q;
    ls_d         = ls_q;
    s_d          = s_q;
    close_d      = close_q;
    ovf_d        = ovf_q;
    side_d       = side_q;
    knot_mode_d  = knot_mode_q;
    x_d          = x_q;
    acc_len_d    = acc_len_q;
    acc_rise_d   = acc_rise_q;
    acc_sl_d     = acc_sl_q;
    em_level_d   = em_level_q;
    em_len_d     = em_len_q;
    fl_k_d       = fl_k_q;
    pend_v_d     = pend_v_q;
    pend_level_d = pend_level_q;
    pend_len_d   = pend_len_q;
    ovalid_d     = ovalid_q && !out_o.ready;
    o_level_d    = o_level_q;
    o_len_d      = o_len_q;
    o_last_d     = o_last_q;
    o_ovf_d      = o_ovf_q;

    up_we = 1'b0; up_waddr = '0; up_wdata = '0; up_re = 1'b0; up_raddr = '0;
    lo_we = 1'b0; lo_waddr = '0; lo_wdata = '0; lo_re = 1'b0; lo_raddr = '0;

    div_req.start = 1'b0;
    div_req.num   = acc_rise_q;
    div_req.den   = acc_len_q;

    in_i.ready = 1'b0;

    cnt_inc  = count_q + CW'(1);
    in_ovf   = !in_i.last_sample && (cnt_inc >= CW'(tsd_pkg::MAX_LEN));
    in_close = in_i.last_sample || in_ovf;
    in_first = (count_q == '0);
    in_pt    = passthru_q || (in_first && ((lambda_q == '0) || in_close));
    r_u      = in_ext - start_ext - cfg_lam_ext;
    r_l      = in_ext - start_ext + cfg_lam_ext;
    merge    = 1'b0;
    nrise    = '0;
    nlen     = '0;

    case (state_q)
      tsd_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          count_d = cnt_inc;
          s_d     = in_i.sample;
          close_d = in_close;
          ovf_d   = in_ovf;
          if (in_first) begin
            lam_d = lambda_q;
          end
          if (in_pt) begin
            passthru_d = 1'b1;
            state_d    = tsd_pkg::ST_PT_EMIT;
          end else if (in_first) begin
            // both deques start with one unit segment
            up_we    = 1'b1;
            up_wdata = SW'(tsd_pkg::seg_t'{len: CW'(1), rise: r_u,
                                           slope: tsd_pkg::sat32(tsd_pkg::CMP_W'(r_u))});
            lo_we    = 1'b1;
            lo_wdata = SW'(tsd_pkg::seg_t'{len: CW'(1), rise: r_l,
                                           slope: tsd_pkg::sat32(tsd_pkg::CMP_W'(r_l))});
            uh_d     = '0;
            us_d     = CW'(1);
            lh_d     = '0;
            ls_d     = CW'(1);
            knot_x_d = '0;
            knot_y_d = start_ext;
            exp_x_d  = CW'(1);
            exp_y_d  = in_ext;
          end else begin
            side_d  = 1'b0;
            x_d     = in_close ? (in_ext + lam_ext) : in_ext;
            state_d = tsd_pkg::ST_ADD_START;
          end
        end
      end

      tsd_pkg::ST_PT_EMIT: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          o_level_d = s_q;
          o_len_d   = CW'(1);
          o_last_d  = close_q;
          o_ovf_d   = ovf_q;
          if (close_q) begin
            passthru_d = 1'b0;
            count_d    = '0;
            lam_d      = '0;
          end
          state_d = tsd_pkg::ST_IDLE;
        end
      end

      tsd_pkg::ST_ADD_START: begin
        knot_mode_d = 1'b0;
        acc_len_d   = CW'(1);
        acc_rise_d  = x_q;
        acc_sl_d    = tsd_pkg::sat32(tsd_pkg::CMP_W'(x_q));
        if (cur_size == '0) begin
          state_d = tsd_pkg::ST_PUSH;
        end else begin
          if (side_q) begin
            lo_re = 1'b1; lo_raddr = tail_sum[IW-1:0];
          end else begin
            up_re = 1'b1; up_raddr = tail_sum[IW-1:0];
          end
          state_d = tsd_pkg::ST_ADD_FIRST;
        end
      end

      tsd_pkg::ST_ADD_FIRST, tsd_pkg::ST_ADD_MERGE: begin
        if (state_q == tsd_pkg::ST_ADD_FIRST) begin
          merge = side_q ? (acc_sl_q < cur_rd.slope) : (acc_sl_q > cur_rd.slope);
        end else begin
          merge = side_q ? (rise_c < prod_c) : (rise_c > prod_c);
        end
        if (!merge) begin
          state_d = (state_q == tsd_pkg::ST_ADD_FIRST) ? tsd_pkg::ST_PUSH
                                                       : tsd_pkg::ST_DIV_GO;
        end else begin
          // pop the tail into the accumulated segment
          acc_len_d  = acc_len_q + cur_rd.len;
          acc_rise_d = acc_rise_q + cur_rd.rise;
          if (side_q) begin
            ls_d = ls_q - CW'(1);
          end else begin
            us_d = us_q - CW'(1);
          end
          if (cur_size == CW'(1)) begin
            state_d = tsd_pkg::ST_DIV_GO;
          end else begin
            if (side_q) begin
              lo_re = 1'b1; lo_raddr = next_tail_sum[IW-1:0];
            end else begin
              up_re = 1'b1; up_raddr = next_tail_sum[IW-1:0];
            end
            state_d = tsd_pkg::ST_ADD_MERGE;
          end
        end
      end

      tsd_pkg::ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_d       = tsd_pkg::ST_DIV_WAIT;
      end

      tsd_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          acc_sl_d = div_rsp.quo;
          state_d  = tsd_pkg::ST_PUSH;
        end
      end

      tsd_pkg::ST_PUSH: begin
        if (knot_mode_q) begin
          // the opposite deque was cleared and restarts with one segment
          if (side_q) begin
            lo_we = 1'b1; lo_waddr = '0; lo_wdata = SW'(wseg);
            lh_d  = '0;   ls_d = CW'(1);
          end else begin
            up_we = 1'b1; up_waddr = '0; up_wdata = SW'(wseg);
            uh_d  = '0;   us_d = CW'(1);
          end
          state_d = tsd_pkg::ST_KNOT_EMIT;
        end else begin
          if (push_pos < (CW+1)'(tsd_pkg::MAX_LEN)) begin
            if (side_q) begin
              lo_we = 1'b1; lo_waddr = push_pos[IW-1:0]; lo_wdata = SW'(wseg);
              ls_d  = ls_q + CW'(1);
            end else begin
              up_we = 1'b1; up_waddr = push_pos[IW-1:0]; up_wdata = SW'(wseg);
              us_d  = us_q + CW'(1);
            end
          end
          if (!side_q) begin
            side_d  = 1'b1;
            x_d     = close_q ? (s_ext - lam_ext) : s_ext;
            state_d = tsd_pkg::ST_ADD_START;
          end else if (close_q) begin
            // drain the larger deque, lower on a tie
            side_d   = (us_q > ls_d) ? 1'b0 : 1'b1;
            fl_k_d   = '0;
            pend_v_d = 1'b0;
            state_d  = tsd_pkg::ST_FL_RD;
          end else begin
            exp_x_d = exp_x_q + CW'(1);
            exp_y_d = exp_y_q + s_ext;
            state_d = tsd_pkg::ST_KNOT_RD;
          end
        end
      end

      tsd_pkg::ST_KNOT_RD: begin
        if ((us_q == '0) || (ls_q == '0)) begin
          state_d = tsd_pkg::ST_IDLE;
        end else begin
          up_re = 1'b1; up_raddr = uh_q[IW-1:0];
          lo_re = 1'b1; lo_raddr = lh_q[IW-1:0];
          state_d = tsd_pkg::ST_KNOT_CMP;
        end
      end

      tsd_pkg::ST_KNOT_CMP: begin
        if (lo_rd.slope < up_rd.slope) begin
          if (lo_rd.len < up_rd.len) begin
            em_level_d = lo_rd.slope;
            em_len_d   = lo_rd.len;
            lh_d       = lh_q + CW'(1);
            ls_d       = ls_q - CW'(1);
            nlen       = exp_x_q - knot_x_q - lo_rd.len;
            nrise      = exp_y_q - lam_ext - knot_y_q - lo_rd.rise;
            knot_x_d   = knot_x_q + lo_rd.len;
            knot_y_d   = knot_y_q + lo_rd.rise;
            side_d     = 1'b0;
          end else begin
            em_level_d = up_rd.slope;
            em_len_d   = up_rd.len;
            uh_d       = uh_q + CW'(1);
            us_d       = us_q - CW'(1);
            nlen       = exp_x_q - knot_x_q - up_rd.len;
            nrise      = exp_y_q + lam_ext - knot_y_q - up_rd.rise;
            knot_x_d   = knot_x_q + up_rd.len;
            knot_y_d   = knot_y_q + up_rd.rise;
            side_d     = 1'b1;
          end
          acc_len_d   = nlen;
          acc_rise_d  = nrise;
          knot_mode_d = 1'b1;
          state_d     = tsd_pkg::ST_DIV_GO;
        end else begin
          state_d = tsd_pkg::ST_IDLE;
        end
      end

      tsd_pkg::ST_KNOT_EMIT: begin
        if (em_len_q == '0) begin
          state_d = tsd_pkg::ST_KNOT_RD;
        end else if (out_free) begin
          ovalid_d  = 1'b1;
          o_level_d = em_level_q;
          o_len_d   = em_len_q;
          o_last_d  = 1'b0;
          o_ovf_d   = 1'b0;
          state_d   = tsd_pkg::ST_KNOT_RD;
        end
      end

      tsd_pkg::ST_FL_RD: begin
        if (fl_k_q == cur_size) begin
          state_d = tsd_pkg::ST_FL_END;
        end else begin
          if (side_q) begin
            lo_re = 1'b1; lo_raddr = tail_sum[IW-1:0] - cur_size[IW-1:0]
                                     + IW'(1) + fl_k_q[IW-1:0];
          end else begin
            up_re = 1'b1; up_raddr = tail_sum[IW-1:0] - cur_size[IW-1:0]
                                     + IW'(1) + fl_k_q[IW-1:0];
          end
          state_d = tsd_pkg::ST_FL_DATA;
        end
      end

      tsd_pkg::ST_FL_DATA: begin
        // one run is held back so the final one can carry last_run
        if (cur_rd.len == '0) begin
          fl_k_d  = fl_k_q + CW'(1);
          state_d = tsd_pkg::ST_FL_RD;
        end else if (!pend_v_q) begin
          pend_v_d     = 1'b1;
          pend_level_d = cur_rd.slope;
          pend_len_d   = cur_rd.len;
          fl_k_d       = fl_k_q + CW'(1);
          state_d      = tsd_pkg::ST_FL_RD;
        end else if (out_free) begin
          ovalid_d     = 1'b1;
          o_level_d    = pend_level_q;
          o_len_d      = pend_len_q;
          o_last_d     = 1'b0;
          o_ovf_d      = ovf_q;
          pend_level_d = cur_rd.slope;
          pend_len_d   = cur_rd.len;
          fl_k_d       = fl_k_q + CW'(1);
          state_d      = tsd_pkg::ST_FL_RD;
        end
      end

      tsd_pkg::ST_FL_END: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            ovalid_d  = 1'b1;
            o_level_d = pend_level_q;
            o_len_d   = pend_len_q;
            o_last_d  = 1'b1;
            o_ovf_d   = ovf_q;
          end
          pend_v_d   = 1'b0;
          uh_d       = '0;
          us_d       = '0;
          lh_d       = '0;
          ls_d       = '0;
          knot_x_d   = '0;
          knot_y_d   = '0;
          exp_x_d    = '0;
          exp_y_d    = '0;
          count_d    = '0;
          passthru_d = 1'b0;
          lam_d      = '0;
          state_d    = tsd_pkg::ST_IDLE;
        end
      end

      default: state_d = tsd_pkg::ST_IDLE;
    endcase
  end

  tsd_ram #(.WIDTH(SW), .DEPTH(tsd_pkg::MAX_LEN)) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (up_waddr),
    .wdata_i (up_wdata),
    .re_i    (up_re),
    .raddr_i (up_raddr),
    .rdata_o (up_rdata)
  );

  tsd_ram #(.WIDTH(SW), .DEPTH(tsd_pkg::MAX_LEN)) u_lower_ram (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (lo_waddr),
    .wdata_i (lo_wdata),
    .re_i    (lo_re),
    .raddr_i (lo_raddr),
    .rdata_o (lo_rdata)
  );

  tsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsd_pkg::ST_IDLE;
      lambda_q     <= '0;
      start_q      <= '0;
      lam_q        <= '0;
      passthru_q   <= 1'b0;
      count_q      <= '0;
      knot_x_q     <= '0;
      knot_y_q     <= '0;
      exp_x_q      <= '0;
      exp_y_q      <= '0;
      uh_q         <= '0;
      us_q         <= '0;
      lh_q         <= '0;
      ls_q         <= '0;
      side_q       <= 1'b0;
      knot_mode_q  <= 1'b0;
      pend_v_q     <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      lambda_q     <= lambda_d;
      start_q      <= start_d;
      lam_q        <= lam_d;
      passthru_q   <= passthru_d;
      count_q      <= count_d;
      knot_x_q     <= knot_x_d;
      knot_y_q     <= knot_y_d;
      exp_x_q      <= exp_x_d;
      exp_y_q      <= exp_y_d;
      uh_q         <= uh_d;
      us_q         <= us_d;
      lh_q         <= lh_d;
      ls_q         <= ls_d;
      side_q       <= side_d;
      knot_mode_q  <= knot_mode_d;
      pend_v_q     <= pend_v_d;
      ovalid_q     <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s_q          <= s_d;
    close_q      <= close_d;
    ovf_q        <= ovf_d;
    x_q          <= x_d;
    acc_len_q    <= acc_len_d;
    acc_rise_q   <= acc_rise_d;
    acc_sl_q     <= acc_sl_d;
    em_level_q   <= em_level_d;
    em_len_q     <= em_len_d;
    fl_k_q       <= fl_k_d;
    pend_level_q <= pend_level_d;
    pend_len_q   <= pend_len_d;
    o_level_q    <= o_level_d;
    o_len_q      <= o_len_d;
    o_last_q     <= o_last_d;
    o_ovf_q      <= o_ovf_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.level      = o_level_q;
  assign out_o.run_length = o_len_q;
  assign out_o.last_run   = o_last_q;
  assign out_o.overflow   = o_ovf_q;

endmodule
`default_nettype wire
